@@ sv/lru_k_cache_policy_unit_assert.svh @@
// Assertion macros for the LRU-K policy unit checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef LRU_K_CACHE_POLICY_UNIT_ASSERT_SVH
`define LRU_K_CACHE_POLICY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LKC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define LKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lkc_pkg.sv @@
// Shared types and codes for the LRU-K policy unit.
// No dependencies.
package lkc_pkg;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic REG_HIT_THRESHOLD = 1'b0;
  localparam logic REG_LIST_CAPACITY = 1'b1;

  localparam logic LIST_HISTORY = 1'b0;
  localparam logic LIST_CACHE   = 1'b1;

  typedef enum logic [2:0] {
    KIND_MISS    = 3'd0,
    KIND_HHIT    = 3'd1,
    KIND_PROMOTE = 3'd2,
    KIND_CHIT    = 3'd3,
    KIND_ENTRY   = 3'd4,
    KIND_EMPTY   = 3'd5
  } kind_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] key;
  } in_beat_t;

  typedef struct packed {
    kind_t       kind;
    logic        list_sel;
    logic [15:0] entry_key;
    logic        evicted;
    logic        last;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_TRIM_H, ST_TRIM_C, ST_REMOVE, ST_APPEND,
    ST_FINISH, ST_REP_H, ST_REP_C
  } state_t;

  typedef struct packed {
    logic load;
    logic search;
    logic trim_h;
    logic trim_c;
    logic remove;
    logic append;
    logic finish;
    logic rep_h;
    logic rep_c;
  } cmd_t;

  typedef struct packed {
    logic is_report;
    logic h_over;
    logic c_over;
    logic out_free;
    logic rep_h_done;
    logic rep_c_done;
  } status_t;

endpackage

@@ sv/lru_k_cache_policy_unit.sv @@
// LRU-K replacement policy unit: a history list and a cache list, each up
// to CAPACITY keys held oldest first in shift registers and searched in
// parallel. An access steps through search, two trim checks, remove, append
// and finish, and no new item is taken until the sequencer is back in idle;
// each extra entry dropped after a capacity cut adds a further trim step, and
// a stalled output holds the sequencer. A report gives one result per entry
// of the history list and then of the cache list, an empty list giving one
// empty marker.
// Depends on lkc_pkg, lkc_ctrl and lkc_dpath.
module lru_k_cache_policy_unit #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lkc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lkc_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [5:0]         cfg_wdata
);

  lkc_pkg::cmd_t    cmd;
  lkc_pkg::status_t sts;

  lkc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lkc_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ sv/lkc_ctrl.sv @@
// Sequencer for the LRU-K policy unit: steps an access or a report.
// Depends on lkc_pkg.
module lkc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lkc_pkg::status_t sts,
  output lkc_pkg::cmd_t    cmd
);

  lkc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.is_report ? lkc_pkg::ST_REP_H : lkc_pkg::ST_SEARCH;
        end
      end
      lkc_pkg::ST_SEARCH: state_nxt = lkc_pkg::ST_TRIM_H;
      lkc_pkg::ST_TRIM_H: begin
        if (!sts.h_over) state_nxt = lkc_pkg::ST_TRIM_C;
      end
      lkc_pkg::ST_TRIM_C: begin
        if (!sts.c_over) state_nxt = lkc_pkg::ST_REMOVE;
      end
      lkc_pkg::ST_REMOVE: state_nxt = lkc_pkg::ST_APPEND;
      lkc_pkg::ST_APPEND: begin
        if (sts.out_free) state_nxt = lkc_pkg::ST_FINISH;
      end
      lkc_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = lkc_pkg::ST_IDLE;
      end
      lkc_pkg::ST_REP_H: begin
        if (sts.out_free && sts.rep_h_done) state_nxt = lkc_pkg::ST_REP_C;
      end
      lkc_pkg::ST_REP_C: begin
        if (sts.out_free && sts.rep_c_done) state_nxt = lkc_pkg::ST_IDLE;
      end
      default: state_nxt = lkc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      lkc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      lkc_pkg::ST_SEARCH: cmd.search = 1'b1;
      lkc_pkg::ST_TRIM_H: cmd.trim_h = sts.h_over && sts.out_free;
      lkc_pkg::ST_TRIM_C: cmd.trim_c = sts.c_over && sts.out_free;
      lkc_pkg::ST_REMOVE: cmd.remove = 1'b1;
      lkc_pkg::ST_APPEND: cmd.append = sts.out_free;
      lkc_pkg::ST_FINISH: cmd.finish = sts.out_free;
      lkc_pkg::ST_REP_H:  cmd.rep_h  = sts.out_free;
      lkc_pkg::ST_REP_C:  cmd.rep_c  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ sv/lkc_dpath.sv @@
// Datapath of the LRU-K policy unit: both ordered lists, config registers,
// eviction hold stage and output register. Depends on lkc_pkg.
module lkc_dpath #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lkc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lkc_pkg::out_beat_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [5:0]          cfg_wdata,
  input  lkc_pkg::cmd_t       cmd,
  output lkc_pkg::status_t    sts
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KW = KEY_BITS;

  function automatic logic [15:0] to_port(input logic [KW-1:0] k);
    logic [KW+15:0] t;
    t = {16'b0, k};
    return t[15:0];
  endfunction

  logic [KW-1:0] hkey_r [CAPACITY];
  logic [KW-1:0] hkey_nxt [CAPACITY];
  logic [5:0]    hhit_r [CAPACITY];
  logic [5:0]    hhit_nxt [CAPACITY];
  logic [KW-1:0] ckey_r [CAPACITY];
  logic [KW-1:0] ckey_nxt [CAPACITY];
  logic [CW-1:0] hcnt_r, hcnt_nxt, ccnt_r, ccnt_nxt;
  logic [5:0]    thr_r;
  logic [4:0]    lcap_r;
  logic [KW-1:0] key_r, key_nxt;
  lkc_pkg::kind_t kind_r, kind_nxt;
  logic [6:0]    hnew_r, hnew_nxt;
  logic          fc_r, fc_nxt, fh_r, fh_nxt;
  logic          hold_v_r, hold_v_nxt, hold_sel_r, hold_sel_nxt;
  logic [KW-1:0] hold_key_r, hold_key_nxt;
  logic          out_valid_r, out_valid_nxt;
  lkc_pkg::out_beat_t out_data_r, out_data_nxt;
  logic [IW-1:0] idx_r, idx_nxt;

  logic [KW+15:0] kin_ext;
  logic [KW-1:0]  kin;
  logic [5:0]     lc6, capv, thr_eff;
  logic [CW-1:0]  cap, hlo, clo;
  logic [CAPACITY-1:0] hpm, cpm, hwin, cwin;
  logic [IW-1:0]  hp, cp, hwp;
  logic [6:0]     s_h;
  logic           out_free, rep_h_done, rep_c_done;

  assign kin_ext = {{KW{1'b0}}, in_data.key};
  assign kin     = kin_ext[KW-1:0];

  assign lc6  = {1'b0, lcap_r};
  assign capv = (lcap_r == 5'd0) ? 6'd1 :
                (lc6 > 6'(CAPACITY)) ? 6'(CAPACITY) : lc6;
  assign cap  = CW'(capv);
  assign thr_eff = (thr_r == 6'd0) ? 6'd1 : thr_r;
  assign hlo = (hcnt_r > cap) ? hcnt_r - cap : '0;
  assign clo = (ccnt_r > cap) ? ccnt_r - cap : '0;

  // Key matches; the windowed view ignores entries the pending trim drops.
  always_comb begin
    hp  = '0;
    cp  = '0;
    hwp = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hpm[i]  = (hkey_r[i] == key_r) && (CW'(i) < hcnt_r);
      cpm[i]  = (ckey_r[i] == key_r) && (CW'(i) < ccnt_r);
      hwin[i] = hpm[i] && (CW'(i) >= hlo);
      cwin[i] = cpm[i] && (CW'(i) >= clo);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hpm[i])  hp  = IW'(i);
      if (cpm[i])  cp  = IW'(i);
      if (hwin[i]) hwp = IW'(i);
    end
  end

  assign s_h = {1'b0, hhit_r[hwp]} + 7'd1;

  assign out_free   = !out_valid_r || !out_stall;
  assign rep_h_done = (hcnt_r == '0) || ((CW'(idx_r) + CW'(1)) == hcnt_r);
  assign rep_c_done = (ccnt_r == '0) || ((CW'(idx_r) + CW'(1)) == ccnt_r);

  assign sts.is_report  = (in_data.opcode == lkc_pkg::OP_REPORT);
  assign sts.h_over     = hcnt_r > cap;
  assign sts.c_over     = ccnt_r > cap;
  assign sts.out_free   = out_free;
  assign sts.rep_h_done = rep_h_done;
  assign sts.rep_c_done = rep_c_done;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    hkey_nxt      = hkey_r;
    hhit_nxt      = hhit_r;
    ckey_nxt      = ckey_r;
    hcnt_nxt      = hcnt_r;
    ccnt_nxt      = ccnt_r;
    key_nxt       = key_r;
    kind_nxt      = kind_r;
    hnew_nxt      = hnew_r;
    fc_nxt        = fc_r;
    fh_nxt        = fh_r;
    hold_v_nxt    = hold_v_r;
    hold_sel_nxt  = hold_sel_r;
    hold_key_nxt  = hold_key_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    idx_nxt       = idx_r;

    if (cmd.load) begin
      key_nxt = kin;
    end

    if (cmd.search) begin
      fc_nxt   = |cwin;
      fh_nxt   = |hwin;
      hnew_nxt = s_h;
      if (|cwin) begin
        kind_nxt = lkc_pkg::KIND_CHIT;
      end else if (|hwin) begin
        kind_nxt = (s_h >= {1'b0, thr_eff}) ? lkc_pkg::KIND_PROMOTE : lkc_pkg::KIND_HHIT;
      end else begin
        kind_nxt = (thr_eff <= 6'd1) ? lkc_pkg::KIND_PROMOTE : lkc_pkg::KIND_MISS;
      end
    end

    // Evictions pass through the hold stage so the final one can carry last.
    if (cmd.trim_h || cmd.trim_c ||
        (cmd.append && (kind_r == lkc_pkg::KIND_PROMOTE || kind_r == lkc_pkg::KIND_CHIT)
         && ccnt_r >= cap && ccnt_r != '0) ||
        (cmd.append && (kind_r == lkc_pkg::KIND_MISS || kind_r == lkc_pkg::KIND_HHIT)
         && hcnt_r >= cap && hcnt_r != '0)) begin
      if (hold_v_r) begin
        out_data_nxt  = '{kind: kind_r, list_sel: hold_sel_r,
                          entry_key: to_port(hold_key_r), evicted: 1'b1, last: 1'b0};
        out_valid_nxt = 1'b1;
      end
      hold_v_nxt = 1'b1;
    end

    if (cmd.trim_h) begin
      hold_sel_nxt = lkc_pkg::LIST_HISTORY;
      hold_key_nxt = hkey_r[0];
      for (int i = 0; i < CAPACITY - 1; i++) begin
        hkey_nxt[i] = hkey_r[i+1];
        hhit_nxt[i] = hhit_r[i+1];
      end
      hcnt_nxt = hcnt_r - CW'(1);
    end

    if (cmd.trim_c) begin
      hold_sel_nxt = lkc_pkg::LIST_CACHE;
      hold_key_nxt = ckey_r[0];
      for (int i = 0; i < CAPACITY - 1; i++) begin
        ckey_nxt[i] = ckey_r[i+1];
      end
      ccnt_nxt = ccnt_r - CW'(1);
    end

    if (cmd.remove) begin
      if (fc_r) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IW'(i) >= cp) ckey_nxt[i] = ckey_r[i+1];
        end
        ccnt_nxt = ccnt_r - CW'(1);
      end else if (fh_r) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IW'(i) >= hp) begin
            hkey_nxt[i] = hkey_r[i+1];
            hhit_nxt[i] = hhit_r[i+1];
          end
        end
        hcnt_nxt = hcnt_r - CW'(1);
      end
    end

    if (cmd.append) begin
      if (kind_r == lkc_pkg::KIND_PROMOTE || kind_r == lkc_pkg::KIND_CHIT) begin
        if (ccnt_r >= cap && ccnt_r != '0) begin
          hold_sel_nxt = lkc_pkg::LIST_CACHE;
          hold_key_nxt = ckey_r[0];
          for (int i = 0; i < CAPACITY - 1; i++) begin
            ckey_nxt[i] = ckey_r[i+1];
          end
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == ccnt_r - CW'(1)) ckey_nxt[i] = key_r;
          end
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == ccnt_r) ckey_nxt[i] = key_r;
          end
          ccnt_nxt = ccnt_r + CW'(1);
        end
      end else begin
        if (hcnt_r >= cap && hcnt_r != '0) begin
          hold_sel_nxt = lkc_pkg::LIST_HISTORY;
          hold_key_nxt = hkey_r[0];
          for (int i = 0; i < CAPACITY - 1; i++) begin
            hkey_nxt[i] = hkey_r[i+1];
            hhit_nxt[i] = hhit_r[i+1];
          end
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == hcnt_r - CW'(1)) begin
              hkey_nxt[i] = key_r;
              hhit_nxt[i] = (kind_r == lkc_pkg::KIND_MISS) ? 6'd1 : hnew_r[5:0];
            end
          end
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == hcnt_r) begin
              hkey_nxt[i] = key_r;
              hhit_nxt[i] = (kind_r == lkc_pkg::KIND_MISS) ? 6'd1 : hnew_r[5:0];
            end
          end
          hcnt_nxt = hcnt_r + CW'(1);
        end
      end
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (hold_v_r) begin
        out_data_nxt = '{kind: kind_r, list_sel: hold_sel_r,
                         entry_key: to_port(hold_key_r), evicted: 1'b1, last: 1'b1};
      end else begin
        out_data_nxt = '{kind: kind_r, list_sel: lkc_pkg::LIST_HISTORY,
                         entry_key: 16'd0, evicted: 1'b0, last: 1'b1};
      end
      hold_v_nxt = 1'b0;
    end

    if (cmd.rep_h) begin
      out_valid_nxt = 1'b1;
      if (hcnt_r == '0) begin
        out_data_nxt = '{kind: lkc_pkg::KIND_EMPTY, list_sel: lkc_pkg::LIST_HISTORY,
                         entry_key: 16'd0, evicted: 1'b0, last: 1'b0};
      end else begin
        out_data_nxt = '{kind: lkc_pkg::KIND_ENTRY, list_sel: lkc_pkg::LIST_HISTORY,
                         entry_key: to_port(hkey_r[idx_r]), evicted: 1'b0, last: 1'b0};
      end
      idx_nxt = rep_h_done ? '0 : idx_r + IW'(1);
    end

    if (cmd.rep_c) begin
      out_valid_nxt = 1'b1;
      if (ccnt_r == '0) begin
        out_data_nxt = '{kind: lkc_pkg::KIND_EMPTY, list_sel: lkc_pkg::LIST_CACHE,
                         entry_key: 16'd0, evicted: 1'b0, last: rep_c_done};
      end else begin
        out_data_nxt = '{kind: lkc_pkg::KIND_ENTRY, list_sel: lkc_pkg::LIST_CACHE,
                         entry_key: to_port(ckey_r[idx_r]), evicted: 1'b0,
                         last: rep_c_done};
      end
      idx_nxt = rep_c_done ? '0 : idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r      <= '0;
      ccnt_r      <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      thr_r       <= 6'd2;
      lcap_r      <= 5'd16;
    end else begin
      hcnt_r      <= hcnt_nxt;
      ccnt_r      <= ccnt_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          lkc_pkg::REG_HIT_THRESHOLD: thr_r  <= cfg_wdata;
          lkc_pkg::REG_LIST_CAPACITY: lcap_r <= cfg_wdata[4:0];
          default: thr_r <= thr_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hkey_r     <= hkey_nxt;
    hhit_r     <= hhit_nxt;
    ckey_r     <= ckey_nxt;
    key_r      <= key_nxt;
    kind_r     <= kind_nxt;
    hnew_r     <= hnew_nxt;
    fc_r       <= fc_nxt;
    fh_r       <= fh_nxt;
    hold_sel_r <= hold_sel_nxt;
    hold_key_r <= hold_key_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ sv/lkc_checker.sv @@
// Port-level checks for the LRU-K policy unit, bound to the top level.
// Depends on lkc_pkg and lru_k_cache_policy_unit_assert.svh.
`include "lru_k_cache_policy_unit_assert.svh"

module lkc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input lkc_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input lkc_pkg::out_beat_t out_data,
  input logic               cfg_we,
  input logic               cfg_addr,
  input logic [5:0]         cfg_wdata
);

  `LKC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `LKC_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")
  `LKC_ASSERT_NOW(a_evict_kind, out_valid && out_data.evicted, out_data.kind == lkc_pkg::KIND_MISS || out_data.kind == lkc_pkg::KIND_HHIT || out_data.kind == lkc_pkg::KIND_PROMOTE || out_data.kind == lkc_pkg::KIND_CHIT, "eviction on report beat")
  `LKC_ASSERT_NOW(a_empty_zero, out_valid && out_data.kind == lkc_pkg::KIND_EMPTY, out_data.entry_key == 16'd0 && !out_data.evicted, "empty marker carries a key")

endmodule

bind lru_k_cache_policy_unit lkc_checker u_lkc_checker (.*);
